>>> rtl/core/rpopg_pkg.sv
`default_nettype none

package rpopg_pkg;

	localparam int WORD_W = 64;
	localparam int HALF_W = 32;

	// splitmix64 constants
	localparam logic [WORD_W-1:0] GOLDEN_STEP = 64'h9e37_79b9_7f4a_7c15;
	localparam logic [WORD_W-1:0] MIX_MUL_ONE = 64'hbf58_476d_1ce4_e5b9;
	localparam logic [WORD_W-1:0] MIX_MUL_TWO = 64'h94d0_49bb_1331_11eb;
	localparam int MIX_SHIFT_ONE = 30;
	localparam int MIX_SHIFT_TWO = 27;
	localparam int MIX_SHIFT_OUT = 31;

	// xoroshiro128+ step
	localparam int ROT_A   = 55;
	localparam int SHIFT_B = 14;
	localparam int ROT_C   = 36;

	localparam logic [7:0] BYTE_ONES  = 8'hFF;
	localparam logic [7:0] BYTE_ZEROS = 8'h00;
	localparam int STRIPE_BIT = 2;

	localparam logic [1:0] MODE_STRIPED = 2'd0;
	localparam logic [1:0] MODE_ONES    = 2'd1;
	localparam logic [1:0] MODE_ZEROS   = 2'd2;
	localparam logic [1:0] MODE_RANDOM  = 2'd3;

	localparam logic REG_FILL_MODE = 1'b0;
	localparam logic REG_SEED      = 1'b1;

	localparam logic CMD_RESTART = 1'b0;
	localparam logic CMD_FILL    = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_START1 = 5'b00010,
		ST_WAIT1  = 5'b00100,
		ST_START2 = 5'b01000,
		ST_WAIT2  = 5'b10000
	} seq_state_t;

endpackage

`default_nettype wire

>>> rtl/core/rpopg_mul64lo.sv
`default_nettype none

// Low 64 bits of a 64x64 product, built from three 32x32 partial products
// on one shared multiplier. Result valid while done is high.
module rpopg_mul64lo
	import rpopg_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [WORD_W-1:0] a,
	input  wire logic [WORD_W-1:0] b,
	output logic                   done,
	output logic [WORD_W-1:0]      product
);

	logic [WORD_W-1:0] a_q;
	logic [WORD_W-1:0] b_q;
	logic [WORD_W-1:0] part_q;
	logic [WORD_W-1:0] acc_q;
	logic [1:0]        step_q;
	logic              busy_q;
	logic [HALF_W-1:0] op_x;
	logic [HALF_W-1:0] op_y;
	logic [WORD_W-1:0] mul_out;
	logic [WORD_W-1:0] part_hi;

	// pick the partial product for this step
	always_comb begin
		case (step_q)
			2'd0: begin
				op_x = a_q[HALF_W-1:0];
				op_y = b_q[HALF_W-1:0];
			end
			2'd1: begin
				op_x = a_q[HALF_W-1:0];
				op_y = b_q[WORD_W-1:HALF_W];
			end
			default: begin
				op_x = a_q[WORD_W-1:HALF_W];
				op_y = b_q[HALF_W-1:0];
			end
		endcase
	end

	assign mul_out = {{HALF_W{1'b0}}, op_x} * {{HALF_W{1'b0}}, op_y};
	assign part_hi = {part_q[HALF_W-1:0], {HALF_W{1'b0}}};
	assign done    = busy_q && (step_q == 2'd3);
	assign product = acc_q + part_hi;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= 2'd0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= 2'd0;
		end else if (busy_q) begin
			step_q <= step_q + 2'd1;
			if (step_q == 2'd3) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
		end
		part_q <= mul_out;
		if (step_q == 2'd1) begin
			acc_q <= part_q;
		end else if (step_q == 2'd2) begin
			acc_q <= acc_q + part_hi;
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/ram_power_on_pattern_generator_core.sv
`default_nettype none

// Power-on fill pattern generator. Each transaction on the item channel is
// either a restart (command 0) or a fill request (command 1). A fill request
// returns one fill_byte on the result channel: mode 0 gives stripes (0xFF
// where position bit 2 is set, unless zero_fill), mode 1 all ones, mode 2
// all zeros, mode 3 the low byte of a xoroshiro128+ generator, which then
// advances. Fill requests can be accepted every cycle while no restart is running
// and the result side keeps up; an output register holds the byte until it is
// taken. A restart returns nothing; it expands seed_value through two
// splitmix64 steps into the 128-bit generator state and keeps item_ready low
// until the expansion finishes: four 64-bit multiplications, each a launch
// state followed by a wait on the shared 32x32 multiplier unit. Write fill_mode
// (index 0) and seed_value (index 1) only while the block is idle. Random
// fill before any restart runs from the all-zero state and yields zeros.
module ram_power_on_pattern_generator_core
	import rpopg_pkg::*;
#(
	parameter int POSITION_BITS = 16
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_write,
	input  wire logic                     cfg_index,
	input  wire logic [WORD_W-1:0]        cfg_data,
	input  wire logic                     item_valid,
	output logic                          item_ready,
	input  wire logic                     command,
	input  wire logic [POSITION_BITS-1:0] position,
	input  wire logic                     zero_fill,
	output logic                          result_valid,
	input  wire logic                     result_ready,
	output logic [7:0]                    fill_byte
);

	seq_state_t        state_q;
	logic              half_q;
	logic [1:0]        mode_q;
	logic [WORD_W-1:0] seed_q;
	logic [WORD_W-1:0] ctr_q;
	logic [WORD_W-1:0] z_q;
	logic [WORD_W-1:0] word_a_q;
	logic [WORD_W-1:0] word_b_q;
	logic              result_valid_q;
	logic [7:0]        fill_byte_q;

	logic              item_fire;
	logic              fill_fire;
	logic              restart_fire;
	logic              mul_start;
	logic [WORD_W-1:0] mul_a;
	logic [WORD_W-1:0] mul_b;
	logic              mul_done;
	logic [WORD_W-1:0] mul_p;
	logic [WORD_W-1:0] mix_out;
	logic [WORD_W-1:0] xs_s1;
	logic [WORD_W-1:0] next_a;
	logic [WORD_W-1:0] next_b;
	logic [7:0]        rand_byte;
	logic [7:0]        byte_sel;

	// Accept while idle and the output register is free or draining.
	assign item_ready   = (state_q == ST_IDLE) && (!result_valid_q || result_ready);
	assign item_fire    = item_valid && item_ready;
	assign fill_fire    = item_fire && (command == CMD_FILL);
	assign restart_fire = item_fire && (command == CMD_RESTART);

	assign result_valid = result_valid_q;
	assign fill_byte    = fill_byte_q;

	// Shared multiplier: first mix stage in START1, second in START2.
	assign mul_start = (state_q == ST_START1) || (state_q == ST_START2);
	assign mul_a = (state_q == ST_START1) ? (ctr_q ^ (ctr_q >> MIX_SHIFT_ONE))
	                                      : (z_q ^ (z_q >> MIX_SHIFT_TWO));
	assign mul_b = (state_q == ST_START1) ? MIX_MUL_ONE : MIX_MUL_TWO;

	rpopg_mul64lo u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.a       (mul_a),
		.b       (mul_b),
		.done    (mul_done),
		.product (mul_p)
	);

	assign mix_out = mul_p ^ (mul_p >> MIX_SHIFT_OUT);

	// One xoroshiro128+ step; only the low byte of the sum is needed.
	assign rand_byte = word_a_q[7:0] + word_b_q[7:0];
	assign xs_s1  = word_b_q ^ word_a_q;
	assign next_a = ((word_a_q << ROT_A) | (word_a_q >> (WORD_W - ROT_A)))
	                ^ xs_s1 ^ (xs_s1 << SHIFT_B);
	assign next_b = (xs_s1 << ROT_C) | (xs_s1 >> (WORD_W - ROT_C));

	always_comb begin
		case (mode_q)
			MODE_ONES:   byte_sel = BYTE_ONES;
			MODE_ZEROS:  byte_sel = BYTE_ZEROS;
			MODE_RANDOM: byte_sel = rand_byte;
			default:     byte_sel = (!zero_fill && position[STRIPE_BIT]) ? BYTE_ONES
			                                                             : BYTE_ZEROS;
		endcase
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_STRIPED;
			seed_q <= '0;
		end else if (cfg_write) begin
			if (cfg_index == REG_FILL_MODE) begin
				mode_q <= cfg_data[1:0];
			end else begin
				seed_q <= cfg_data;
			end
		end
	end

	// Restart sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			half_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (restart_fire) begin
						half_q  <= 1'b0;
						state_q <= ST_START1;
					end
				end
				ST_START1: state_q <= ST_WAIT1;
				ST_WAIT1: begin
					if (mul_done) begin
						state_q <= ST_START2;
					end
				end
				ST_START2: state_q <= ST_WAIT2;
				ST_WAIT2: begin
					if (mul_done) begin
						// second expansion done: back to idle
						if (half_q) begin
							state_q <= ST_IDLE;
						end else begin
							half_q  <= 1'b1;
							state_q <= ST_START1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Seed counter and intermediate mix value
	always_ff @(posedge clk) begin
		if (restart_fire) begin
			ctr_q <= seed_q + GOLDEN_STEP;
		end else if ((state_q == ST_WAIT2) && mul_done && !half_q) begin
			ctr_q <= ctr_q + GOLDEN_STEP;
		end
		if ((state_q == ST_WAIT1) && mul_done) begin
			z_q <= mul_p;
		end
	end

	// Generator state: load on restart, advance on random fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_a_q <= '0;
			word_b_q <= '0;
		end else if ((state_q == ST_WAIT2) && mul_done) begin
			if (half_q) begin
				word_b_q <= mix_out;
			end else begin
				word_a_q <= mix_out;
			end
		end else if (fill_fire && (mode_q == MODE_RANDOM)) begin
			word_a_q <= next_a;
			word_b_q <= next_b;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (fill_fire) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fill_fire) begin
			fill_byte_q <= byte_sel;
		end
	end

	// A held result blocks new transactions.
	a_hold_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready) |-> !item_ready)
		else $error("item accepted while result stalled");

	// The multiplier only finishes while the sequencer waits on it.
	a_mul_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> ((state_q == ST_WAIT1) || (state_q == ST_WAIT2)))
		else $error("multiplier done outside a wait state");

	// A restart starts the first expansion.
	a_restart_seq: assert property (@(posedge clk) disable iff (!arst_n)
		restart_fire |=> ((state_q == ST_START1) && !half_q && !item_ready))
		else $error("restart did not launch the seed expansion");

	// Non-random fills leave the generator alone.
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_fire && (mode_q != MODE_RANDOM)) |=> ($stable(word_a_q) && $stable(word_b_q)))
		else $error("generator state changed outside random fill");

endmodule

`default_nettype wire
